// ===== sv/aeff_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helpers for the aligned extent free-range finder.
package aeff_pkg;

  localparam int DW        = 50;            // exact width of gap bounds
  localparam int AW        = 21;            // alignment register width
  localparam int REM_STEPS = 5;             // remainder bits per cycle
  localparam int REM_CYC   = DW / REM_STEPS;
  localparam int RCW       = $clog2(REM_CYC);

  localparam logic [47:0] MASK48 = '1;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_FIRST  = 3'd2;
  localparam logic [2:0] OP_LARGE  = 3'd3;
  localparam logic [2:0] OP_TOTAL  = 3'd4;
  localparam logic [2:0] OP_SLOT   = 3'd5;

  localparam logic [1:0] KIND_PRIMARY  = 2'd0;
  localparam logic [1:0] KIND_EXTENDED = 2'd1;
  localparam logic [1:0] KIND_LOGICAL  = 2'd2;
  localparam logic [1:0] KIND_BAD      = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOSPACE  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOSLOT   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_NOEXT    = 3'd5;

  localparam logic [1:0] CFG_ALIGN  = 2'd0;
  localparam logic [1:0] CFG_ASTART = 2'd1;
  localparam logic [1:0] CFG_ALEN   = 2'd2;

  typedef struct packed {
    logic [47:0] start;
    logic [47:0] len;
    logic [7:0]  slot;
  } pent_t;

  typedef struct packed {
    logic [47:0] start;
    logic [47:0] len;
  } lent_t;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] dividend;
    logic [AW-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic          done;
    logic [AW-1:0] rem;
  } rem_rsp_t;

  function automatic logic [47:0] sat48(input logic [DW-1:0] x);
    logic [47:0] y;
    y = (x > {2'b00, MASK48}) ? MASK48 : x[47:0];
    return y;
  endfunction

endpackage

// ===== sv/aeff_rem.sv =====
`timescale 1ns / 1ps
// Multi-cycle remainder unit: dividend modulo alignment, several bits per cycle.
module aeff_rem (
  input  logic                clk,
  input  logic                rst_n,
  input  aeff_pkg::rem_req_t  req,
  output aeff_pkg::rem_rsp_t  rsp
);

  logic [aeff_pkg::DW-1:0]  q_r, q_nxt;
  logic [aeff_pkg::AW-1:0]  r_r, r_nxt, d_r;
  logic [aeff_pkg::AW:0]    t;
  logic [aeff_pkg::RCW-1:0] cnt_r;
  logic                     busy_r, done_r;

  // restoring steps, dividend MSB first
  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    t     = '0;
    for (int k = 0; k < aeff_pkg::REM_STEPS; k++) begin
      t     = {r_nxt, q_nxt[aeff_pkg::DW-1]};
      q_nxt = {q_nxt[aeff_pkg::DW-2:0], 1'b0};
      if (t >= {1'b0, d_r}) t = t - {1'b0, d_r};
      r_nxt = t[aeff_pkg::AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == aeff_pkg::RCW'(aeff_pkg::REM_CYC - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r <= req.dividend;
      r_r <= '0;
      d_r <= req.divisor;
    end else if (busy_r) begin
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = r_r;

endmodule

// ===== sv/aligned_extent_free_range_finder_top.sv =====
`timescale 1ns / 1ps
// Status-only errors are reported straight from the idle state; insert, remove and
// free slot walk the table entry by entry; gap queries wait on the shared remainder
// unit for each alignment, two alignments per entry. One request at a time; busy
// stays high until the result strobe. The receiver cannot stall results.
// Reset (synchronous, rst_n low) clears counts, extended extent and config to defaults;
// table memories are not cleared.
module aligned_extent_free_range_finder_top #(
  parameter int MAX_EXTENTS = 64,
  parameter int MAX_SLOTS   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic        in_space,
  input  logic [1:0]  in_extent_kind,
  input  logic [47:0] in_extent_start,
  input  logic [47:0] in_extent_length,
  input  logic [7:0]  in_slot_index,
  input  logic [47:0] in_needed_blocks,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [47:0] out_range_start,
  output logic [47:0] out_range_length,
  output logic [47:0] out_free_total,
  output logic [7:0]  out_free_slot,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);

  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int DW = aeff_pkg::DW;
  localparam int AW = aeff_pkg::AW;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_INS_RD = 5'd1;
  localparam logic [4:0] S_INS_CK = 5'd2;
  localparam logic [4:0] S_INS_WR = 5'd3;
  localparam logic [4:0] S_RM_RD  = 5'd4;
  localparam logic [4:0] S_RM_CK  = 5'd5;
  localparam logic [4:0] S_SH_RD  = 5'd6;
  localparam logic [4:0] S_SH_WR  = 5'd7;
  localparam logic [4:0] S_RM_END = 5'd8;
  localparam logic [4:0] S_B0     = 5'd9;
  localparam logic [4:0] S_SC_RD  = 5'd10;
  localparam logic [4:0] S_SC_ST  = 5'd11;
  localparam logic [4:0] S_DN     = 5'd12;
  localparam logic [4:0] S_GAP    = 5'd13;
  localparam logic [4:0] S_UP     = 5'd14;
  localparam logic [4:0] S_RES    = 5'd15;
  localparam logic [4:0] S_SL_RD  = 5'd16;
  localparam logic [4:0] S_SL_CK  = 5'd17;
  localparam logic [4:0] S_SL_END = 5'd18;

  // configuration and control state
  logic [AW-1:0] align_r;
  logic [47:0]   area_start_r, area_len_r;
  logic [47:0]   ext_start_r, ext_len_r;
  logic          ext_present_r;
  logic [CW-1:0] pcount_r, lcount_r;
  logic [4:0]    state_r;
  logic [CW-1:0] i_r, n_r;

  // latched request
  logic [2:0]  op_r;
  logic [1:0]  kind_r;
  logic        sel_r;
  logic [47:0] st_r, len_r, need_r;
  logic [7:0]  slot_r;

  // scan state
  logic [DW-1:0] x_r, e_r, hi_r, b0_r, b1_r;
  logic [AW-1:0] hdr_r;
  logic          fin_r, rem_go_r;
  logic          ff_found_r;
  logic [DW-1:0] ff_start_r, ff_len_r, best_start_r, best_len_r;
  logic [47:0]   total_r;
  logic [MAX_SLOTS-1:0] mask_r;

  // result register
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [47:0] out_rs_r, out_rl_r, out_tot_r;
  logic [7:0]  out_slot_r;

  // memories
  aeff_pkg::pent_t pmem [0:MAX_EXTENTS-1];
  aeff_pkg::lent_t lmem [0:MAX_EXTENTS-1];
  aeff_pkg::pent_t prd_r, wdat_p;
  aeff_pkg::lent_t lrd_r, wdat_l;
  logic [IW-1:0]   raddr, waddr;
  logic            we, we_p, we_l;
  logic [CW-1:0]   im1;

  aeff_pkg::rem_req_t rem_req;
  aeff_pkg::rem_rsp_t rem_rsp;

  logic [AW-1:0] a_eff, am1;
  logic [47:0]   rd_start, rd_len, lo48, ln48;
  logic [CW-1:0] cnt_sel, cnt_in;
  logic          accept;
  logic [DW-1:0] nb, nbh;
  logic [DW:0]   tsum;
  logic          fs_found;
  logic [7:0]    fs_val;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign a_eff    = (align_r == '0) ? AW'(1) : align_r;
  assign am1      = a_eff - AW'(1);
  assign rd_start = sel_r ? lrd_r.start : prd_r.start;
  assign rd_len   = sel_r ? lrd_r.len : prd_r.len;
  assign cnt_sel  = sel_r ? lcount_r : pcount_r;
  assign lo48     = in_space ? ext_start_r : area_start_r;
  assign ln48     = in_space ? ext_len_r : area_len_r;
  assign cnt_in   = (in_extent_kind == aeff_pkg::KIND_LOGICAL) ? lcount_r : pcount_r;
  assign im1      = i_r - CW'(1);

  assign rem_req.start    = rem_go_r;
  assign rem_req.dividend = x_r;
  assign rem_req.divisor  = a_eff;

  aeff_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  // memory access control
  always_comb begin
    raddr  = i_r[IW-1:0];
    waddr  = i_r[IW-1:0];
    we     = 1'b0;
    wdat_p = prd_r;
    wdat_l = lrd_r;
    case (state_r)
      S_INS_RD: raddr = im1[IW-1:0];
      S_INS_CK: we = (rd_start > st_r);
      S_INS_WR: begin
        we     = 1'b1;
        wdat_p = '{start: st_r, len: len_r, slot: slot_r};
        wdat_l = '{start: st_r, len: len_r};
      end
      S_SH_RD:  raddr = CW'(i_r + CW'(1)) > CW'(0) ? i_r[IW-1:0] + IW'(1) : i_r[IW-1:0];
      S_SH_WR:  we = 1'b1;
      default:  ;
    endcase
  end

  assign we_p = we && !sel_r;
  assign we_l = we && sel_r;

  always_ff @(posedge clk) begin
    if (we_p) pmem[waddr] <= wdat_p;
    prd_r <= pmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (we_l) lmem[waddr] <= wdat_l;
    lrd_r <= lmem[raddr];
  end

  // gap evaluation for S_GAP
  always_comb begin
    nb   = b1_r - b0_r;
    nbh  = nb - {{(DW-AW){1'b0}}, hdr_r};
    tsum = {{(DW-47){1'b0}}, total_r} + {1'b0, nbh};
  end

  always_comb begin
    fs_found = 1'b0;
    fs_val   = '0;
    for (int j = MAX_SLOTS - 1; j >= 0; j--) begin
      if (!mask_r[j]) begin
        fs_found = 1'b1;
        fs_val   = 8'(j + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_r       <= AW'(1);
      area_start_r  <= '0;
      area_len_r    <= '0;
      ext_start_r   <= '0;
      ext_len_r     <= '0;
      ext_present_r <= 1'b0;
      pcount_r      <= '0;
      lcount_r      <= '0;
      state_r       <= S_IDLE;
      rem_go_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      rem_go_r    <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          aeff_pkg::CFG_ALIGN:  align_r      <= cfg_wdata[AW-1:0];
          aeff_pkg::CFG_ASTART: area_start_r <= cfg_wdata;
          aeff_pkg::CFG_ALEN:   area_len_r   <= cfg_wdata;
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r         <= in_operation;
            kind_r       <= in_extent_kind;
            st_r         <= in_extent_start;
            len_r        <= in_extent_length;
            slot_r       <= in_slot_index;
            need_r       <= in_needed_blocks;
            out_rs_r     <= '0;
            out_rl_r     <= '0;
            out_tot_r    <= '0;
            out_slot_r   <= '0;
            i_r          <= (in_operation == aeff_pkg::OP_INSERT) ? cnt_in : '0;
            case (in_operation)
              aeff_pkg::OP_INSERT: begin
                sel_r <= (in_extent_kind == aeff_pkg::KIND_LOGICAL);
                if (in_extent_kind == aeff_pkg::KIND_BAD) begin
                  out_status_r <= aeff_pkg::ST_NOTFOUND;
                  out_valid_r  <= 1'b1;
                end else if (cnt_in == CW'(MAX_EXTENTS)) begin
                  out_status_r <= aeff_pkg::ST_FULL;
                  out_valid_r  <= 1'b1;
                end else begin
                  out_status_r <= aeff_pkg::ST_OK;
                  state_r      <= (cnt_in == '0) ? S_INS_WR : S_INS_RD;
                end
              end
              aeff_pkg::OP_REMOVE: begin
                sel_r <= in_space;
                if ((in_space ? lcount_r : pcount_r) == '0) begin
                  out_status_r <= aeff_pkg::ST_NOTFOUND;
                  out_valid_r  <= 1'b1;
                end else begin
                  out_status_r <= aeff_pkg::ST_OK;
                  state_r      <= S_RM_RD;
                end
              end
              aeff_pkg::OP_FIRST, aeff_pkg::OP_LARGE, aeff_pkg::OP_TOTAL: begin
                sel_r <= in_space;
                if (in_space && !ext_present_r) begin
                  out_status_r <= aeff_pkg::ST_NOEXT;
                  out_valid_r  <= 1'b1;
                end else begin
                  out_status_r <= aeff_pkg::ST_OK;
                  x_r          <= {2'b00, lo48} + {{(DW-AW){1'b0}}, am1};
                  hi_r         <= {2'b00, lo48} + {2'b00, ln48};
                  hdr_r        <= in_space ? a_eff : '0;
                  n_r          <= in_space ? lcount_r : pcount_r;
                  fin_r        <= 1'b0;
                  ff_found_r   <= 1'b0;
                  ff_start_r   <= '0;
                  ff_len_r     <= '0;
                  best_start_r <= '0;
                  best_len_r   <= '0;
                  total_r      <= '0;
                  rem_go_r     <= 1'b1;
                  state_r      <= S_B0;
                end
              end
              aeff_pkg::OP_SLOT: begin
                out_status_r <= aeff_pkg::ST_OK;
                sel_r        <= 1'b0;
                mask_r       <= '0;
                state_r      <= (pcount_r == '0) ? S_SL_END : S_SL_RD;
              end
              default: begin
                out_status_r <= aeff_pkg::ST_OK;
                out_valid_r  <= 1'b1;
              end
            endcase
          end
        end

        // insert: walk down from the top, moving larger starts up one place
        S_INS_RD: state_r <= S_INS_CK;
        S_INS_CK: begin
          if (rd_start > st_r) begin
            i_r     <= im1;
            state_r <= (i_r == CW'(1)) ? S_INS_WR : S_INS_RD;
          end else begin
            state_r <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          if (sel_r) lcount_r <= lcount_r + CW'(1);
          else pcount_r <= pcount_r + CW'(1);
          if (kind_r == aeff_pkg::KIND_EXTENDED) begin
            ext_start_r   <= st_r;
            ext_len_r     <= len_r;
            ext_present_r <= 1'b1;
          end
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end

        // remove: find first match, then close the hole
        S_RM_RD: state_r <= S_RM_CK;
        S_RM_CK: begin
          if (rd_start == st_r) begin
            state_r <= (i_r + CW'(1) == cnt_sel) ? S_RM_END : S_SH_RD;
          end else if (i_r + CW'(1) == cnt_sel) begin
            out_status_r <= aeff_pkg::ST_NOTFOUND;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end else begin
            i_r     <= i_r + CW'(1);
            state_r <= S_RM_RD;
          end
        end
        S_SH_RD: state_r <= S_SH_WR;
        S_SH_WR: begin
          i_r     <= i_r + CW'(1);
          state_r <= (i_r + CW'(2) == cnt_sel) ? S_RM_END : S_SH_RD;
        end
        S_RM_END: begin
          if (sel_r) lcount_r <= lcount_r - CW'(1);
          else begin
            pcount_r <= pcount_r - CW'(1);
            if (ext_present_r && ext_start_r == st_r) ext_present_r <= 1'b0;
          end
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end

        // gap scan
        S_B0: begin
          if (rem_rsp.done) begin
            b0_r <= x_r - {{(DW-AW){1'b0}}, rem_rsp.rem};
            if (i_r == n_r) begin
              x_r      <= hi_r;
              fin_r    <= 1'b1;
              rem_go_r <= 1'b1;
              state_r  <= S_DN;
            end else begin
              state_r <= S_SC_RD;
            end
          end
        end
        S_SC_RD: state_r <= S_SC_ST;
        S_SC_ST: begin
          x_r      <= {2'b00, rd_start};
          e_r      <= {2'b00, rd_start} + {2'b00, rd_len} + {{(DW-AW){1'b0}}, am1};
          rem_go_r <= 1'b1;
          state_r  <= S_DN;
        end
        S_DN: begin
          if (rem_rsp.done) begin
            b1_r    <= x_r - {{(DW-AW){1'b0}}, rem_rsp.rem};
            state_r <= S_GAP;
          end
        end
        S_GAP: begin
          if (b1_r >= b0_r) begin
            if (!ff_found_r && nb >= {2'b00, need_r}) begin
              ff_found_r <= 1'b1;
              ff_start_r <= b0_r;
              ff_len_r   <= nb;
            end
            if (nb > best_len_r) begin
              best_start_r <= b0_r;
              best_len_r   <= nb;
            end
            if (nb > {{(DW-AW){1'b0}}, hdr_r}) begin
              total_r <= (tsum > {{(DW-47){1'b0}}, aeff_pkg::MASK48}) ?
                         aeff_pkg::MASK48 : tsum[47:0];
            end
          end
          if (fin_r) begin
            state_r <= S_RES;
          end else begin
            x_r      <= e_r;
            rem_go_r <= 1'b1;
            state_r  <= S_UP;
          end
        end
        S_UP: begin
          if (rem_rsp.done) begin
            b0_r <= x_r - {{(DW-AW){1'b0}}, rem_rsp.rem};
            i_r  <= i_r + CW'(1);
            if (i_r + CW'(1) == n_r) begin
              x_r      <= hi_r;
              fin_r    <= 1'b1;
              rem_go_r <= 1'b1;
              state_r  <= S_DN;
            end else begin
              state_r <= S_SC_RD;
            end
          end
        end
        S_RES: begin
          case (op_r)
            aeff_pkg::OP_FIRST: begin
              if (ff_found_r) begin
                out_rs_r <= aeff_pkg::sat48(ff_start_r);
                out_rl_r <= aeff_pkg::sat48(ff_len_r);
              end else begin
                out_status_r <= aeff_pkg::ST_NOSPACE;
              end
            end
            aeff_pkg::OP_LARGE: begin
              if (best_len_r != '0) begin
                out_rs_r <= aeff_pkg::sat48(best_start_r);
                out_rl_r <= aeff_pkg::sat48(best_len_r);
              end else begin
                out_status_r <= aeff_pkg::ST_NOSPACE;
              end
            end
            default: out_tot_r <= total_r;
          endcase
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end

        // free slot: collect used slots, then pick the lowest clear one
        S_SL_RD: state_r <= S_SL_CK;
        S_SL_CK: begin
          for (int j = 0; j < MAX_SLOTS; j++) begin
            if (prd_r.slot == 8'(j + 1)) mask_r[j] <= 1'b1;
          end
          i_r     <= i_r + CW'(1);
          state_r <= (i_r + CW'(1) == pcount_r) ? S_SL_END : S_SL_RD;
        end
        S_SL_END: begin
          if (fs_found) out_slot_r <= fs_val;
          else out_status_r <= aeff_pkg::ST_NOSLOT;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_range_start  = out_rs_r;
  assign out_range_length = out_rl_r;
  assign out_free_total   = out_tot_r;
  assign out_free_slot    = out_slot_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pcount_r <= CW'(MAX_EXTENTS) && lcount_r <= CW'(MAX_EXTENTS))
    else $error("table count beyond capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(pcount_r) |-> out_valid_r)
    else $error("primary count changed without a result");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != aeff_pkg::ST_OK |->
      out_rs_r == '0 && out_rl_r == '0 && out_tot_r == '0 && out_slot_r == '0)
    else $error("nonzero result fields with error status");

  a_rem_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rem_rsp.done |-> state_r == S_B0 || state_r == S_DN || state_r == S_UP)
    else $error("remainder finished outside a wait state");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy) || $past(accept))
    else $error("result without request");

endmodule

// ===== tb/extent_finder_checker.sv =====
`timescale 1ns / 1ps
// Checker for the extent free-range finder: predicts each result and compares it.
module extent_finder_checker #(
  parameter int MAX_EXTENTS = 64,
  parameter int MAX_SLOTS   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_operation,
  input  logic        in_space,
  input  logic [1:0]  in_extent_kind,
  input  logic [47:0] in_extent_start,
  input  logic [47:0] in_extent_length,
  input  logic [7:0]  in_slot_index,
  input  logic [47:0] in_needed_blocks,
  input  logic        out_valid,
  input  logic [2:0]  out_status,
  input  logic [47:0] out_range_start,
  input  logic [47:0] out_range_length,
  input  logic [47:0] out_free_total,
  input  logic [7:0]  out_free_slot,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] rstart;
    logic [47:0] rlen;
    logic [47:0] total;
    logic [7:0]  slot;
  } finder_result_t;

  finder_result_t expected_results[$];

  logic [20:0] align_q;
  logic [47:0] area_start_q, area_len_q;
  logic [47:0] p_start [MAX_EXTENTS];
  logic [47:0] p_len   [MAX_EXTENTS];
  logic [7:0]  p_slot  [MAX_EXTENTS];
  logic [47:0] l_start [MAX_EXTENTS];
  logic [47:0] l_len   [MAX_EXTENTS];
  int          p_count, l_count;
  logic [47:0] ext_start, ext_len;
  bit          ext_present;

  function automatic logic [63:0] sat(logic [63:0] x);
    return (x > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : x;
  endfunction

  function automatic void take_gap(logic [63:0] b0, logic [63:0] b1, logic [63:0] need,
                                   logic [63:0] hdr, inout bit ff_hit,
                                   inout logic [63:0] ff_s, inout logic [63:0] ff_l,
                                   inout logic [63:0] big_s, inout logic [63:0] big_l,
                                   inout logic [63:0] sum);
    logic [63:0] nb;
    if (b1 < b0) return;
    nb = b1 - b0;
    if (!ff_hit && nb >= need) begin
      ff_hit = 1;
      ff_s = b0;
      ff_l = nb;
    end
    if (nb > big_l) begin
      big_s = b0;
      big_l = nb;
    end
    if (nb > hdr) sum += nb - hdr;
  endfunction

  function automatic finder_result_t predict_result(logic [2:0] op, logic sp, logic [1:0] kind,
                                                    logic [47:0] st, logic [47:0] ln,
                                                    logic [7:0] sl, logic [47:0] need);
    finder_result_t r;
    int pos, n, cnt;
    bit used, ff_hit;
    logic [63:0] a, lo, hi, hdr, b0, ff_s, ff_l, big_s, big_l, sum, e;
    r = '0;
    case (op)
      aeff_pkg::OP_INSERT: begin
        if (kind == aeff_pkg::KIND_PRIMARY || kind == aeff_pkg::KIND_EXTENDED) begin
          if (p_count >= MAX_EXTENTS) r.status = aeff_pkg::ST_FULL;
          else begin
            pos = 0;
            while (pos < p_count && p_start[pos] <= st) pos++;
            for (int i = p_count; i > pos; i--) begin
              p_start[i] = p_start[i-1];
              p_len[i]   = p_len[i-1];
              p_slot[i]  = p_slot[i-1];
            end
            p_start[pos] = st;
            p_len[pos]   = ln;
            p_slot[pos]  = sl;
            p_count++;
            if (kind == aeff_pkg::KIND_EXTENDED) begin
              ext_start   = st;
              ext_len     = ln;
              ext_present = 1;
            end
          end
        end else if (kind == aeff_pkg::KIND_LOGICAL) begin
          if (l_count >= MAX_EXTENTS) r.status = aeff_pkg::ST_FULL;
          else begin
            pos = 0;
            while (pos < l_count && l_start[pos] <= st) pos++;
            for (int i = l_count; i > pos; i--) begin
              l_start[i] = l_start[i-1];
              l_len[i]   = l_len[i-1];
            end
            l_start[pos] = st;
            l_len[pos]   = ln;
            l_count++;
          end
        end else r.status = aeff_pkg::ST_NOTFOUND;
      end
      aeff_pkg::OP_REMOVE: begin
        cnt = sp ? l_count : p_count;
        pos = 0;
        while (pos < cnt && (sp ? l_start[pos] : p_start[pos]) != st) pos++;
        if (pos >= cnt) r.status = aeff_pkg::ST_NOTFOUND;
        else if (!sp) begin
          for (int i = pos; i + 1 < p_count; i++) begin
            p_start[i] = p_start[i+1];
            p_len[i]   = p_len[i+1];
            p_slot[i]  = p_slot[i+1];
          end
          p_count--;
          if (ext_present && ext_start == st) ext_present = 0;
        end else begin
          for (int i = pos; i + 1 < l_count; i++) begin
            l_start[i] = l_start[i+1];
            l_len[i]   = l_len[i+1];
          end
          l_count--;
        end
      end
      aeff_pkg::OP_FIRST, aeff_pkg::OP_LARGE, aeff_pkg::OP_TOTAL: begin
        if (sp && !ext_present) begin
          r.status = aeff_pkg::ST_NOEXT;
          return r;
        end
        a = (align_q == 0) ? 64'd1 : 64'(align_q);
        if (!sp) begin
          lo = area_start_q; hi = 64'(area_start_q) + area_len_q; hdr = 0; cnt = p_count;
        end else begin
          lo = ext_start; hi = 64'(ext_start) + ext_len; hdr = a; cnt = l_count;
        end
        ff_hit = 0; ff_s = 0; ff_l = 0; big_s = 0; big_l = 0; sum = 0;
        b0 = ((lo + a - 1) / a) * a;
        for (int i = 0; i < cnt; i++) begin
          e = sp ? l_start[i] : p_start[i];
          take_gap(b0, e - (e % a), need, hdr, ff_hit, ff_s, ff_l, big_s, big_l, sum);
          e = sp ? 64'(l_start[i]) + l_len[i] : 64'(p_start[i]) + p_len[i];
          b0 = ((e + a - 1) / a) * a;
        end
        take_gap(b0, hi - (hi % a), need, hdr, ff_hit, ff_s, ff_l, big_s, big_l, sum);
        if (op == aeff_pkg::OP_FIRST) begin
          if (ff_hit) begin
            r.rstart = sat(ff_s);
            r.rlen   = sat(ff_l);
          end else r.status = aeff_pkg::ST_NOSPACE;
        end else if (op == aeff_pkg::OP_LARGE) begin
          if (big_l != 0) begin
            r.rstart = sat(big_s);
            r.rlen   = sat(big_l);
          end else r.status = aeff_pkg::ST_NOSPACE;
        end else r.total = sat(sum);
      end
      aeff_pkg::OP_SLOT: begin
        r.status = aeff_pkg::ST_NOSLOT;
        for (n = 1; n <= MAX_SLOTS; n++) begin
          used = 0;
          for (int i = 0; i < p_count; i++)
            if (p_slot[i] == n) used = 1;
          if (!used) begin
            r.status = aeff_pkg::ST_OK;
            r.slot   = n[7:0];
            break;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    finder_result_t exp_r, got;
    if (!rst_n) begin
      align_q      <= 21'd1;
      area_start_q <= '0;
      area_len_q   <= '0;
      p_count      = 0;
      l_count      = 0;
      ext_start    = '0;
      ext_len      = '0;
      ext_present  = 0;
      errors       = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          aeff_pkg::CFG_ALIGN:  align_q      <= cfg_wdata[20:0];
          aeff_pkg::CFG_ASTART: area_start_q <= cfg_wdata;
          aeff_pkg::CFG_ALEN:   area_len_q   <= cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy)
        expected_results.push_back(predict_result(in_operation, in_space, in_extent_kind,
            in_extent_start, in_extent_length, in_slot_index, in_needed_blocks));
      if (out_valid) begin
        got = '{out_status, out_range_start, out_range_length, out_free_total, out_free_slot};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, got %h", $time, got);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.status !== exp_r.status) begin
            $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
            errors++;
          end
          if (got.rstart !== exp_r.rstart) begin
            $display("%0t: range_start exp %h got %h", $time, exp_r.rstart, got.rstart);
            errors++;
          end
          if (got.rlen !== exp_r.rlen) begin
            $display("%0t: range_length exp %h got %h", $time, exp_r.rlen, got.rlen);
            errors++;
          end
          if (got.total !== exp_r.total) begin
            $display("%0t: free_total exp %h got %h", $time, exp_r.total, got.total);
            errors++;
          end
          if (got.slot !== exp_r.slot) begin
            $display("%0t: free_slot exp %0d got %0d", $time, exp_r.slot, got.slot);
            errors++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the extent free-range finder: stimulus, configuration and verdict.
module tb_top;

  logic        clk, rst_n, start, busy;
  logic [2:0]  in_operation;
  logic        in_space;
  logic [1:0]  in_extent_kind;
  logic [47:0] in_extent_start, in_extent_length, in_needed_blocks;
  logic [7:0]  in_slot_index;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [47:0] out_range_start, out_range_length, out_free_total;
  logic [7:0]  out_free_slot;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [47:0] cfg_wdata;
  int          errors, pending;

  logic [47:0] base, span, ext_base;
  logic [47:0] prim_starts[$], log_starts[$];
  bit          no_idle;
  int          sent;

  aligned_extent_free_range_finder_top DUT (.*);
  extent_finder_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("aligned_extent_free_range_finder_top test failed");
    $finish;
  end

  function automatic logic [47:0] rand48();
    return {$urandom, $urandom};
  endfunction

  task automatic pause_between();
    int g;
    g = 0;
    if (!no_idle) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4:  g = $urandom_range(1, 3);
        5:              g = $urandom_range(10, 40);
        default:        g = 0;
      endcase
    end
    if (g > 0) begin
      @(negedge clk) start <= 0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic send(logic [2:0] op, logic sp, logic [1:0] kind, logic [47:0] st,
                      logic [47:0] ln, logic [7:0] sl, logic [47:0] need);
    @(negedge clk);
    in_operation     <= op;
    in_space         <= sp;
    in_extent_kind   <= kind;
    in_extent_start  <= st;
    in_extent_length <= ln;
    in_slot_index    <= sl;
    in_needed_blocks <= need;
    start            <= 1;
    do @(posedge clk); while (busy);
    sent++;
    if (op == aeff_pkg::OP_INSERT && kind != aeff_pkg::KIND_BAD) begin
      if (kind == aeff_pkg::KIND_LOGICAL) log_starts.push_back(st);
      else prim_starts.push_back(st);
    end
    pause_between();
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [47:0] val);
    @(negedge clk) start <= 0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 0;
  endtask

  task automatic drop_start(ref logic [47:0] q[$], output logic [47:0] st);
    int k;
    k = $urandom_range(0, q.size() - 1);
    st = q[k];
    q.delete(k);
  endtask

  // one random request; mostly in-area extents so gaps and ordering get exercised
  task automatic random_request();
    int r;
    logic [1:0] kind;
    logic sp;
    logic [47:0] st, ln, need;
    r = $urandom_range(0, 99);
    sp = $urandom_range(0, 1);
    need = ($urandom_range(0, 4) == 0) ? rand48() : 48'($urandom_range(0, 64));
    if (prim_starts.size() + log_starts.size() > 20 && r < 30) r = 40;
    if (r < 30) begin
      case ($urandom_range(0, 19))
        0, 1:   kind = aeff_pkg::KIND_EXTENDED;
        2:      kind = aeff_pkg::KIND_BAD;
        3, 4, 5, 6, 7: kind = aeff_pkg::KIND_LOGICAL;
        default: kind = aeff_pkg::KIND_PRIMARY;
      endcase
      if ($urandom_range(0, 9) < 8)
        st = (kind == aeff_pkg::KIND_LOGICAL ? ext_base : base) +
             $urandom_range(0, 32'(span));
      else st = rand48();
      ln = ($urandom_range(0, 9) < 8) ? 48'($urandom_range(0, 32'(span) / 8)) : rand48();
      send(aeff_pkg::OP_INSERT, $urandom_range(0, 1), kind, st, ln,
           8'($urandom_range(0, 255)), need);
    end else if (r < 50) begin
      st = rand48();
      if ($urandom_range(0, 3) != 0) begin
        if (!sp && prim_starts.size() > 0) drop_start(prim_starts, st);
        else if (sp && log_starts.size() > 0) drop_start(log_starts, st);
      end
      send(aeff_pkg::OP_REMOVE, sp, 2'($urandom_range(0, 3)), st, rand48(), 8'($urandom),
           need);
    end else if (r < 90) begin
      send(3'($urandom_range(aeff_pkg::OP_FIRST, aeff_pkg::OP_TOTAL)), sp,
           2'($urandom_range(0, 3)), rand48(), rand48(), 8'($urandom), need);
    end else if (r < 96) begin
      send(aeff_pkg::OP_SLOT, sp, 2'($urandom_range(0, 3)), rand48(), rand48(),
           8'($urandom), need);
    end else begin
      send(3'($urandom_range(6, 7)), sp, 2'($urandom_range(0, 3)), rand48(), rand48(),
           8'($urandom), rand48());
    end
  endtask

  logic [47:0] ph_align [5] = '{48'd1, 48'd8, 48'd0, 48'd1048576, 48'd3};
  logic [47:0] ph_start [5] = '{48'd0, 48'd100, 48'd0, 48'hFFFF_FFF0_0000, 48'd77};
  logic [47:0] ph_len   [5] = '{48'd1000, 48'd5000, '1, '1, 48'd0};
  logic [47:0] ph_span  [5] = '{48'd1000, 48'd5000, 48'd4000, 48'd40_000_000, 48'd600};

  initial begin
    logic [47:0] st;
    rst_n = 0; start = 0; cfg_valid = 0; cfg_index = aeff_pkg::CFG_ALIGN; cfg_wdata = '0;
    in_operation = aeff_pkg::OP_SLOT; in_space = 0; in_extent_kind = aeff_pkg::KIND_PRIMARY;
    in_extent_start = '0; in_extent_length = '0; in_slot_index = '0; in_needed_blocks = '0;
    no_idle = 0; sent = 0; base = 0; span = 1000; ext_base = 0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1;

    // directed: empty tables, reset config and error codes, then small tables and queries
    send(aeff_pkg::OP_SLOT, 0, aeff_pkg::KIND_PRIMARY, '0, '0, '0, '0);
    send(aeff_pkg::OP_TOTAL, 0, aeff_pkg::KIND_PRIMARY, '0, '0, '0, '0);
    send(aeff_pkg::OP_LARGE, 0, aeff_pkg::KIND_PRIMARY, '0, '0, '0, '0);
    send(aeff_pkg::OP_FIRST, 1, aeff_pkg::KIND_PRIMARY, '0, '0, '0, '0);
    send(aeff_pkg::OP_REMOVE, 0, aeff_pkg::KIND_PRIMARY, 48'd5, '0, '0, '0);
    send(aeff_pkg::OP_INSERT, 0, aeff_pkg::KIND_BAD, 48'd5, 48'd5, '0, '0);
    send(3'd6, 1, aeff_pkg::KIND_BAD, '1, '1, '1, '1);
    send(3'd7, 0, aeff_pkg::KIND_PRIMARY, '0, '0, '0, '0);
    cfg_write(aeff_pkg::CFG_ALIGN, 48'd4);
    cfg_write(aeff_pkg::CFG_ASTART, 48'd10);
    cfg_write(aeff_pkg::CFG_ALEN, '1);
    for (int i = 1; i <= 4; i++)
      send(aeff_pkg::OP_INSERT, 0,
           (i == 2) ? aeff_pkg::KIND_EXTENDED : aeff_pkg::KIND_PRIMARY, 48'(i * 101),
           (i == 2) ? 48'd400 : 48'd7, 8'(i), '0);
    send(aeff_pkg::OP_SLOT, 0, aeff_pkg::KIND_PRIMARY, '0, '0, '0, '0);
    send(aeff_pkg::OP_INSERT, 0, aeff_pkg::KIND_LOGICAL, 48'd250, 48'd9, '0, '0);
    send(aeff_pkg::OP_INSERT, 0, aeff_pkg::KIND_LOGICAL, 48'd250, 48'd30, '0, '0);
    send(aeff_pkg::OP_FIRST, 1, aeff_pkg::KIND_PRIMARY, '0, '0, '0, 48'd50);
    send(aeff_pkg::OP_LARGE, 1, aeff_pkg::KIND_PRIMARY, '0, '0, '0, '0);
    send(aeff_pkg::OP_TOTAL, 1, aeff_pkg::KIND_PRIMARY, '0, '0, '0, '0);
    send(aeff_pkg::OP_INSERT, 0, aeff_pkg::KIND_PRIMARY, '1, '1, 8'hFF, '0);
    send(aeff_pkg::OP_FIRST, 0, aeff_pkg::KIND_PRIMARY, '0, '0, '0, '1);
    send(aeff_pkg::OP_LARGE, 0, aeff_pkg::KIND_PRIMARY, '0, '0, '0, '0);
    send(aeff_pkg::OP_TOTAL, 0, aeff_pkg::KIND_PRIMARY, '0, '0, '0, '0);
    send(aeff_pkg::OP_REMOVE, 0, aeff_pkg::KIND_PRIMARY, 48'd202, '0, '0, '0);
    send(aeff_pkg::OP_TOTAL, 1, aeff_pkg::KIND_PRIMARY, '0, '0, '0, '0);

    // fill both tables past capacity, then empty them
    for (int i = 0; i < 66; i++) begin
      send(aeff_pkg::OP_INSERT, 0, aeff_pkg::KIND_PRIMARY, 48'($urandom_range(0, 3000)),
           48'd3, 8'($urandom_range(0, 5)), '0);
      send(aeff_pkg::OP_INSERT, 0, aeff_pkg::KIND_LOGICAL, 48'($urandom_range(0, 3000)),
           48'd3, '0, '0);
    end
    send(aeff_pkg::OP_INSERT, 0, aeff_pkg::KIND_EXTENDED, 48'd0, 48'd4000, 8'd9, '0);
    send(aeff_pkg::OP_TOTAL, 1, aeff_pkg::KIND_PRIMARY, '0, '0, '0, '0);
    send(aeff_pkg::OP_SLOT, 0, aeff_pkg::KIND_PRIMARY, '0, '0, '0, '0);
    while (prim_starts.size() > 0) begin
      drop_start(prim_starts, st);
      send(aeff_pkg::OP_REMOVE, 0, aeff_pkg::KIND_PRIMARY, st, '0, '0, '0);
    end
    while (log_starts.size() > 0) begin
      drop_start(log_starts, st);
      send(aeff_pkg::OP_REMOVE, 1, aeff_pkg::KIND_PRIMARY, st, '0, '0, '0);
    end

    for (int p = 0; p < 5; p++) begin
      cfg_write(aeff_pkg::CFG_ALIGN, ph_align[p]);
      cfg_write(aeff_pkg::CFG_ASTART, ph_start[p]);
      cfg_write(aeff_pkg::CFG_ALEN, ph_len[p]);
      base = ph_start[p];
      span = ph_span[p];
      ext_base = base + span / 2;
      send(aeff_pkg::OP_INSERT, 0, aeff_pkg::KIND_EXTENDED, ext_base, span / 2,
           8'($urandom_range(0, 4)), '0);
      for (int i = 0; i < 120; i++) begin
        if (i % 60 == 0) no_idle = ($urandom_range(0, 2) == 0);
        random_request();
      end
    end

    @(negedge clk) start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("aligned_extent_free_range_finder_top test passed");
    else
      $display("aligned_extent_free_range_finder_top test failed");
    $finish;
  end

endmodule
